>>> sv/tabl_pkg.sv
// Package for the three-axis biquad low-pass filter.
// Holds the coefficient width, the register index codes and the coefficient bundle.
// Used by the interfaces, the configuration registers, the axis filter and the top level.
package tabl_pkg;

  // Coefficients are signed Q2.22 words.
  localparam int unsigned COEF_W = 24;

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 2'd0,
    REG_A1 = 2'd1,
    REG_A2 = 2'd2
  } cfg_reg_e;

  // Coefficient set shared by all three axes.
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

endpackage

>>> sv/tabl_if.sv
// Handshake interfaces for the three-axis biquad low-pass filter.
// Depends on tabl_pkg for the coefficient and index widths.

// Sample channel: one three-axis word per handshake.
interface tabl_sample_if #(
  parameter int unsigned SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_x;
  logic signed [SampleBits-1:0] sample_y;
  logic signed [SampleBits-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

// Result channel: one filtered three-axis word per handshake.
interface tabl_result_if #(
  parameter int unsigned SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] filtered_x;
  logic signed [SampleBits-1:0] filtered_y;
  logic signed [SampleBits-1:0] filtered_z;

  modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                  input ready);
  modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                  output ready);
endinterface

// Configuration write channel: register index and write data.
interface tabl_cfg_if
  import tabl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [COEF_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> sv/tabl_cfg.sv
// Coefficient registers of the three-axis biquad low-pass filter.
// Depends on tabl_pkg and the tabl_cfg_if interface.
module tabl_cfg
  import tabl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tabl_cfg_if.sink   cfg_i,
  output coef_t      coef_o
);

  coef_t coef_q;
  coef_t coef_d;

  // Writes are always taken; an unknown index leaves the registers alone.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    coef_d = coef_q;
    if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_B0:  coef_d.b0 = cfg_i.wdata;
        REG_A1:  coef_d.a1 = cfg_i.wdata;
        REG_A2:  coef_d.a2 = cfg_i.wdata;
        default: coef_d = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

>>> sv/tabl_axis.sv
// One axis of the biquad low-pass filter: history registers and the output arithmetic.
// Depends on tabl_pkg for the coefficient bundle.
module tabl_axis
  import tabl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  coef_t                         coef_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + 2;
  localparam int unsigned PB_W   = COEF_W + SUM_W;
  localparam int unsigned PA_W   = COEF_W + SAMPLE_BITS;
  localparam int unsigned ACC_W  = COEF_W + SAMPLE_BITS + 4;

  logic signed [SAMPLE_BITS-1:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [SUM_W-1:0]       xsum;
  logic signed [PB_W-1:0]        prod_b;
  logic signed [PA_W-1:0]        prod_a1;
  logic signed [PA_W-1:0]        prod_a2;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       quo;
  logic                          frac_nz;
  logic                          fits;

  // Feedforward taps share b0, so add them first: x + 2*x1 + x2.
  assign xsum = SUM_W'(x_i) + (SUM_W'(x1_q) <<< 1) + SUM_W'(x2_q);

  // Three products and the exact sum in Q(COEF_FRAC_BITS).
  assign prod_b  = coef_i.b0 * xsum;
  assign prod_a1 = coef_i.a1 * y1_q;
  assign prod_a2 = coef_i.a2 * y2_q;
  assign acc     = ACC_W'(prod_b) - ACC_W'(prod_a1) - ACC_W'(prod_a2);

  // Truncate toward zero: a negative value with a nonzero fraction steps up by one.
  // The correction term is kept signed so the shift stays arithmetic.
  assign frac_nz = |acc[COEF_FRAC_BITS-1:0];
  assign quo     = (acc >>> COEF_FRAC_BITS) + $signed(ACC_W'(acc[ACC_W-1] && frac_nz));

  // Saturate to the signed sample range.
  assign fits = (&quo[ACC_W-1:SAMPLE_BITS-1]) || !(|quo[ACC_W-1:SAMPLE_BITS-1]);

  always_comb begin
    if (fits) begin
      y_o = quo[SAMPLE_BITS-1:0];
    end else if (quo[ACC_W-1]) begin
      y_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // History moves one place each time a word is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (en_i) begin
      x1_q <= x_i;
      x2_q <= x1_q;
      y1_q <= y_o;
      y2_q <= y1_q;
    end
  end

endmodule

>>> sv/three_axis_biquad_lowpass.sv
// Top level of the three-axis biquad low-pass filter.
// Depends on tabl_pkg, the interfaces in tabl_if, tabl_cfg and tabl_axis.
//
// Usage:
//   sample_i carries one three-axis word per handshake; result_o returns one
//   filtered word for each. cfg_i writes the coefficients b0, a1 and a2
//   (index 0, 1, 2; other indexes are ignored) and is always ready. Write
//   coefficients only while no word is in flight.
//   An accepted word is latched in the input register; once the result
//   register is free, all three axes compute their outputs and the word
//   lands in the result register, which raises result_o.valid. Throughput
//   is one word per cycle while the receiver does not stall. The history
//   feedback in each axis filter (multiplies, sum, truncate, saturate) is
//   combinational and sets that rate.
//   When the receiver stalls, the result register holds its word and the input
//   register still accepts one more; after that sample_i.ready drops until the
//   result is taken.
//   Reset clears the coefficients, the filter history and both valid flags.
module three_axis_biquad_lowpass
  import tabl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 22
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tabl_sample_if.sink    sample_i,
  tabl_result_if.source  result_o,
  tabl_cfg_if.sink       cfg_i
);

  coef_t coef;

  logic                          in_valid_q;
  logic signed [SAMPLE_BITS-1:0] sx_q, sy_q, sz_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] fx_q, fy_q, fz_q;
  logic signed [SAMPLE_BITS-1:0] fx_d, fy_d, fz_d;
  logic                          fire;
  logic                          accept;

  // Coefficient registers.
  tabl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef)
  );

  // The input word moves to the result register when that register is free.
  assign fire            = in_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready  = !in_valid_q || fire;
  assign accept          = sample_i.valid && sample_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q <= sample_i.sample_x;
      sy_q <= sample_i.sample_y;
      sz_q <= sample_i.sample_z;
    end
  end

  // One filter per axis.
  tabl_axis #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .coef_i (coef),
    .x_i    (sx_q),
    .y_o    (fx_d)
  );

  tabl_axis #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .coef_i (coef),
    .x_i    (sy_q),
    .y_o    (fy_d)
  );

  tabl_axis #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_axis_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .coef_i (coef),
    .x_i    (sz_q),
    .y_o    (fz_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
      fz_q <= fz_d;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.filtered_x = fx_q;
  assign result_o.filtered_y = fy_q;
  assign result_o.filtered_z = fz_q;

endmodule
